FILE: design/bpa_pkg.sv
// Shared constants, datapath command codes and control/status types for the buddy allocator.
package bpa_pkg;

    localparam int NUM_PAGES = 4096;
    localparam int TOP_ORDER = 12;
    localparam int PG_W      = $clog2(NUM_PAGES);
    localparam int LNK_W     = PG_W + 1;
    localparam int ORD_W     = 4;

    // Request function codes
    localparam logic [1:0] FN_INIT  = 2'd0;
    localparam logic [1:0] FN_ALLOC = 2'd1;
    localparam logic [1:0] FN_FREE  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOBLK = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // Datapath command codes
    localparam logic [4:0] OP_NONE    = 5'd0;
    localparam logic [4:0] OP_CLR     = 5'd1;
    localparam logic [4:0] OP_LOAD    = 5'd2;
    localparam logic [4:0] OP_BAD     = 5'd3;
    localparam logic [4:0] OP_INIT    = 5'd4;
    localparam logic [4:0] OP_ICLR    = 5'd5;
    localparam logic [4:0] OP_ISET    = 5'd6;
    localparam logic [4:0] OP_ICARVE  = 5'd7;
    localparam logic [4:0] OP_PUSH1   = 5'd8;
    localparam logic [4:0] OP_PUSH2   = 5'd9;
    localparam logic [4:0] OP_ASTART  = 5'd10;
    localparam logic [4:0] OP_AHIT    = 5'd11;
    localparam logic [4:0] OP_ANEXT   = 5'd12;
    localparam logic [4:0] OP_UL2     = 5'd13;
    localparam logic [4:0] OP_ASPLIT  = 5'd14;
    localparam logic [4:0] OP_ADEC    = 5'd15;
    localparam logic [4:0] OP_AFIN    = 5'd16;
    localparam logic [4:0] OP_NOBLK   = 5'd17;
    localparam logic [4:0] OP_FSTART  = 5'd18;
    localparam logic [4:0] OP_FEV     = 5'd19;
    localparam logic [4:0] OP_FMSTART = 5'd20;
    localparam logic [4:0] OP_FM1     = 5'd21;
    localparam logic [4:0] OP_FM3     = 5'd22;
    localparam logic [4:0] OP_FPUSH   = 5'd23;
    localparam logic [4:0] OP_OK      = 5'd24;
    localparam logic [4:0] OP_EMIT    = 5'd25;

    typedef struct packed {
        logic [4:0] op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       cnt_zero;
        logic       init_ok;
        logic       alloc_ok;
        logic       free_ok;
        logic       clr_done;
        logic       rem_zero;
        logic       rem_one;
        logic       head_hit;
        logic       at_top;
        logic       split_more;
        logic       buddy_in;
        logic       mark_hit;
        logic       merge_more;
        logic       buddy_match;
        logic       out_free;
    } t_sts;

    // Smallest order whose block holds n pages
    function automatic logic [ORD_W-1:0] f_round_order(input logic [12:0] n);
        logic [ORD_W-1:0] ord;
        ord = 4'd13;
        for (int k = 13; k >= 0; k--) begin
            if ((14'(1) << k) >= {1'b0, n}) ord = 4'(k);
        end
        return ord;
    endfunction

    // Largest order not above the top whose block fits in n pages
    function automatic logic [ORD_W-1:0] f_fit_order(input logic [12:0] n);
        logic [ORD_W-1:0] ord;
        ord = '0;
        for (int k = 1; k <= TOP_ORDER; k++) begin
            if ((13'(1) << k) <= n) ord = 4'(k);
        end
        return ord;
    endfunction

endpackage

FILE: design/bpa_dp.sv
// Datapath of the buddy allocator: list heads, page memories, work registers, result register.
module bpa_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  bpa_pkg::t_cmd i_cmd,
    output bpa_pkg::t_sts o_sts,
    input  logic [1:0]    i_func,
    input  logic [11:0]   i_page_index,
    input  logic [12:0]   i_count,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [12:0]   i_cfg_data,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [1:0]    o_status,
    output logic [11:0]   o_block_index,
    output logic [12:0]   o_avail_pages
);
    import bpa_pkg::*;

    localparam logic [LNK_W-1:0] NIL = LNK_W'(NUM_PAGES);

    // Page memories
    logic [ORD_W:0]     mark_mem [NUM_PAGES];
    logic [LNK_W-1:0]   nxt_mem  [NUM_PAGES];
    logic [LNK_W-1:0]   prv_mem  [NUM_PAGES];
    logic [ORD_W:0]     r_mark_q;
    logic [LNK_W-1:0]   r_nxt_q, r_prv_q;

    logic [LNK_W-1:0]   r_head [TOP_ORDER+1];
    logic [12:0]        r_present, r_free, r_cnt, r_cur, r_rem, r_idx;
    logic [LNK_W-1:0]   r_h;
    logic [1:0]         r_func, r_status;
    logic [PG_W-1:0]    r_base, r_ppg, r_upg, r_b, r_blk;
    logic [ORD_W-1:0]   r_o, r_pord, r_uord;

    logic [ORD_W-1:0]   req, fit_ord;
    logic [13:0]        sum_base, req_size;
    logic [PG_W-1:0]    split_b, merge_b, mk_ra, mk_wa, nx_wa, pv_wa;
    logic               mk_we, nx_we, pv_we;
    logic [ORD_W:0]     mk_wd;
    logic [LNK_W-1:0]   nx_wd, pv_wd;

    // Request checks and per-step conditions
    always_comb begin
        req       = f_round_order(r_cnt);
        fit_ord   = f_fit_order(r_rem);
        sum_base  = {2'b0, r_base} + {1'b0, r_cnt};
        req_size  = 14'(1) << req;
        split_b   = r_cur[PG_W-1:0] ^ (PG_W'(1) << (r_o - 4'd1));
        merge_b   = r_cur[PG_W-1:0] ^ (PG_W'(1) << r_o);
        mk_ra     = (i_cmd.op == OP_FM1) ? merge_b : r_idx[PG_W-1:0];

        o_sts.func        = r_func;
        o_sts.cnt_zero    = (r_cnt == '0);
        o_sts.init_ok     = (sum_base <= 14'(NUM_PAGES)) &&
                            ({1'b0, r_free} + {1'b0, r_cnt} <= 14'(NUM_PAGES));
        o_sts.alloc_ok    = (r_cnt <= r_free) && (req <= 4'(TOP_ORDER));
        o_sts.free_ok     = (req <= 4'(TOP_ORDER)) && (sum_base <= 14'(NUM_PAGES)) &&
                            ({1'b0, r_free} + req_size <= 14'(NUM_PAGES));
        o_sts.clr_done    = (r_idx == 13'(NUM_PAGES - 1));
        o_sts.rem_zero    = (r_rem == '0);
        o_sts.rem_one     = (r_rem == 13'd1);
        o_sts.head_hit    = (r_head[r_o] != NIL);
        o_sts.at_top      = (r_o == 4'(TOP_ORDER));
        o_sts.split_more  = (r_o > req);
        o_sts.buddy_in    = ({1'b0, split_b} < r_present);
        o_sts.mark_hit    = r_mark_q[ORD_W];
        o_sts.merge_more  = (r_o < 4'(TOP_ORDER)) && ({1'b0, merge_b} < r_present);
        o_sts.buddy_match = r_mark_q[ORD_W] && (r_mark_q[ORD_W-1:0] == r_o);
        o_sts.out_free    = !o_valid || !i_stall;
    end

    // Select memory writes for the current command
    always_comb begin
        mk_we = 1'b0;
        mk_wa = r_idx[PG_W-1:0];
        mk_wd = '0;
        nx_we = 1'b0;
        nx_wa = r_ppg;
        nx_wd = r_head[r_pord];
        pv_we = 1'b0;
        pv_wa = r_ppg;
        pv_wd = NIL;
        case (i_cmd.op)
            OP_CLR, OP_ICLR: begin
                mk_we = 1'b1;
            end
            OP_PUSH1: begin
                mk_we = 1'b1;
                mk_wa = r_ppg;
                mk_wd = {1'b1, r_pord};
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            OP_PUSH2: begin
                pv_we = (r_h != NIL);
                pv_wa = r_h[PG_W-1:0];
                pv_wd = {1'b0, r_ppg};
            end
            OP_UL2: begin
                nx_we = (r_prv_q != NIL);
                nx_wa = r_prv_q[PG_W-1:0];
                nx_wd = r_nxt_q;
                pv_we = (r_nxt_q != NIL);
                pv_wa = r_nxt_q[PG_W-1:0];
                pv_wd = r_prv_q;
            end
            OP_AFIN: begin
                mk_we = 1'b1;
                mk_wa = r_cur[PG_W-1:0];
            end
            OP_FM3: begin
                mk_we = 1'b1;
                mk_wa = (r_b < r_cur[PG_W-1:0]) ? r_cur[PG_W-1:0] : r_b;
            end
            default: begin
            end
        endcase
    end

    // Page memories, registered reads
    always_ff @(posedge i_clk) begin
        if (mk_we) mark_mem[mk_wa] <= mk_wd;
        if (nx_we) nxt_mem[nx_wa] <= nx_wd;
        if (pv_we) prv_mem[pv_wa] <= pv_wd;
        r_mark_q <= mark_mem[mk_ra];
        r_nxt_q  <= nxt_mem[r_upg];
        r_prv_q  <= prv_mem[r_upg];
    end

    // Control registers: free count, list heads, register, sweep index, result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 13'(NUM_PAGES);
            r_free    <= '0;
            r_idx     <= '0;
            o_valid   <= 1'b0;
            for (int k = 0; k <= TOP_ORDER; k++) r_head[k] <= NIL;
        end else begin
            if (i_cfg_valid && i_cfg_ready) r_present <= i_cfg_data;
            // Raise valid on emit, drop it once the beat is taken
            if (i_cmd.op == OP_EMIT) o_valid <= 1'b1;
            else if (o_valid && !i_stall) o_valid <= 1'b0;
            case (i_cmd.op)
                OP_CLR:    r_idx <= r_idx + 13'd1;
                OP_INIT:   r_idx <= {1'b0, r_base};
                OP_FSTART: r_idx <= {1'b0, r_base};
                OP_ICLR:   r_idx <= r_idx + 13'd1;
                OP_FEV:    r_idx <= r_idx + 13'd1;
                OP_ISET:   r_free <= r_free + r_cnt;
                OP_FMSTART: r_free <= r_free + req_size[12:0];
                OP_AFIN:   r_free <= ({1'b0, r_free} > req_size) ?
                                     r_free - req_size[12:0] : '0;
                OP_PUSH1:  r_head[r_pord] <= {1'b0, r_ppg};
                OP_UL2:    if (r_prv_q == NIL) r_head[r_uord] <= r_nxt_q;
                default: begin
                end
            endcase
        end
    end

    // Work registers and result payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_func <= i_func;
                r_base <= i_page_index;
                r_cnt  <= i_count;
                r_blk  <= '0;
            end
            OP_BAD:   r_status <= ST_BAD;
            OP_NOBLK: r_status <= ST_NOBLK;
            OP_OK:    r_status <= ST_OK;
            OP_INIT:  r_rem <= r_cnt;
            OP_ICLR:  r_rem <= r_rem - 13'd1;
            OP_ISET: begin
                r_cur <= {1'b0, r_base};
                r_rem <= r_cnt;
            end
            OP_ICARVE: begin
                r_pord <= fit_ord;
                r_ppg  <= r_cur[PG_W-1:0];
                r_cur  <= r_cur + (13'(1) << fit_ord);
                r_rem  <= r_rem - (13'(1) << fit_ord);
            end
            OP_PUSH1:  r_h <= r_head[r_pord];
            OP_ASTART: r_o <= req;
            OP_AHIT: begin
                r_cur  <= r_head[r_o];
                r_upg  <= r_head[r_o][PG_W-1:0];
                r_uord <= r_o;
            end
            OP_ANEXT:  r_o <= r_o + 4'd1;
            OP_ADEC:   r_o <= r_o - 4'd1;
            OP_ASPLIT: begin
                r_pord <= r_o - 4'd1;
                r_ppg  <= split_b;
                r_o    <= r_o - 4'd1;
            end
            OP_AFIN: begin
                r_status <= ST_OK;
                r_blk    <= r_cur[PG_W-1:0];
            end
            OP_FSTART: begin
                r_rem <= r_cnt;
                r_o   <= req;
            end
            OP_FEV:     r_rem <= r_rem - 13'd1;
            OP_FMSTART: r_cur <= {1'b0, r_base};
            OP_FM1: begin
                r_b    <= merge_b;
                r_upg  <= merge_b;
                r_uord <= r_o;
            end
            OP_FM3: begin
                if (r_b < r_cur[PG_W-1:0]) r_cur <= {1'b0, r_b};
                r_o <= r_o + 4'd1;
            end
            OP_FPUSH: begin
                r_pord <= r_o;
                r_ppg  <= r_cur[PG_W-1:0];
            end
            OP_EMIT: begin
                o_status      <= r_status;
                o_block_index <= r_blk;
                o_avail_pages <= r_free;
            end
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= 13'(NUM_PAGES))
        else $error("free count above page total");
    a_blk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_block_index == '0))
        else $error("block index set on failed request");
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_EMIT) |=> o_valid)
        else $error("result not presented after emit");
`endif

endmodule

FILE: design/bpa_ctrl.sv
// Controller state machine of the buddy allocator: sequences init, allocate and free steps.
module bpa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  bpa_pkg::t_sts i_sts,
    output bpa_pkg::t_cmd o_cmd
);
    import bpa_pkg::*;

    localparam logic [4:0] S_CLR    = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_DEC    = 5'd2;
    localparam logic [4:0] S_ICLR   = 5'd3;
    localparam logic [4:0] S_ISET   = 5'd4;
    localparam logic [4:0] S_ICARVE = 5'd5;
    localparam logic [4:0] S_PUSH1  = 5'd6;
    localparam logic [4:0] S_PUSH2  = 5'd7;
    localparam logic [4:0] S_ASRCH  = 5'd8;
    localparam logic [4:0] S_UL1    = 5'd9;
    localparam logic [4:0] S_UL2    = 5'd10;
    localparam logic [4:0] S_ASPLIT = 5'd11;
    localparam logic [4:0] S_FRD    = 5'd12;
    localparam logic [4:0] S_FEV    = 5'd13;
    localparam logic [4:0] S_FMS    = 5'd14;
    localparam logic [4:0] S_FM1    = 5'd15;
    localparam logic [4:0] S_FM2    = 5'd16;
    localparam logic [4:0] S_FM3    = 5'd17;
    localparam logic [4:0] S_OKST   = 5'd18;
    localparam logic [4:0] S_FIN    = 5'd19;

    logic [4:0] r_state, n_state, r_ret, n_ret;

    assign o_stall = (r_state != S_IDLE);

    // Next state and datapath command
    always_comb begin
        n_state    = r_state;
        n_ret      = r_ret;
        o_cmd.op   = OP_NONE;
        case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.op = OP_BAD;
                n_state  = S_FIN;
                if (!i_sts.cnt_zero) begin
                    case (i_sts.func)
                        FN_INIT: begin
                            if (i_sts.init_ok) begin
                                o_cmd.op = OP_INIT;
                                n_state  = S_ICLR;
                            end
                        end
                        FN_ALLOC: begin
                            o_cmd.op = i_sts.alloc_ok ? OP_ASTART : OP_NOBLK;
                            n_state  = i_sts.alloc_ok ? S_ASRCH : S_FIN;
                        end
                        FN_FREE: begin
                            if (i_sts.free_ok) begin
                                o_cmd.op = OP_FSTART;
                                n_state  = S_FRD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ICLR: begin
                o_cmd.op = OP_ICLR;
                if (i_sts.rem_one) n_state = S_ISET;
            end
            S_ISET: begin
                o_cmd.op = OP_ISET;
                n_state  = S_ICARVE;
            end
            S_ICARVE: begin
                if (i_sts.rem_zero) begin
                    o_cmd.op = OP_OK;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_ICARVE;
                    n_state  = S_PUSH1;
                    n_ret    = S_ICARVE;
                end
            end
            S_PUSH1: begin
                o_cmd.op = OP_PUSH1;
                n_state  = S_PUSH2;
            end
            S_PUSH2: begin
                o_cmd.op = OP_PUSH2;
                n_state  = r_ret;
            end
            S_ASRCH: begin
                if (i_sts.head_hit) begin
                    o_cmd.op = OP_AHIT;
                    n_state  = S_UL1;
                    n_ret    = S_ASPLIT;
                end else if (i_sts.at_top) begin
                    o_cmd.op = OP_NOBLK;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_ANEXT;
                end
            end
            S_UL1: begin
                n_state = S_UL2;
            end
            S_UL2: begin
                o_cmd.op = OP_UL2;
                n_state  = r_ret;
            end
            S_ASPLIT: begin
                if (!i_sts.split_more) begin
                    o_cmd.op = OP_AFIN;
                    n_state  = S_FIN;
                end else if (i_sts.buddy_in) begin
                    o_cmd.op = OP_ASPLIT;
                    n_state  = S_PUSH1;
                    n_ret    = S_ASPLIT;
                end else begin
                    o_cmd.op = OP_ADEC;
                end
            end
            S_FRD: begin
                n_state = S_FEV;
            end
            S_FEV: begin
                if (i_sts.mark_hit) begin
                    o_cmd.op = OP_BAD;
                    n_state  = S_FIN;
                end else begin
                    o_cmd.op = OP_FEV;
                    n_state  = i_sts.rem_one ? S_FMS : S_FRD;
                end
            end
            S_FMS: begin
                o_cmd.op = OP_FMSTART;
                n_state  = S_FM1;
            end
            S_FM1: begin
                if (i_sts.merge_more) begin
                    o_cmd.op = OP_FM1;
                    n_state  = S_FM2;
                end else begin
                    o_cmd.op = OP_FPUSH;
                    n_state  = S_PUSH1;
                    n_ret    = S_OKST;
                end
            end
            S_FM2: begin
                if (i_sts.buddy_match) begin
                    n_state = S_UL1;
                    n_ret   = S_FM3;
                end else begin
                    o_cmd.op = OP_FPUSH;
                    n_state  = S_PUSH1;
                    n_ret    = S_OKST;
                end
            end
            S_FM3: begin
                o_cmd.op = OP_FM3;
                n_state  = S_FM1;
            end
            S_OKST: begin
                o_cmd.op = OP_OK;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_LOAD) |-> (r_state == S_IDLE))
        else $error("request loaded outside idle");
    a_load_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_LOAD) |=> (r_state == S_DEC))
        else $error("decode skipped after load");
    a_emit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_EMIT) |=> !o_stall)
        else $error("not idle after result");
`endif

endmodule

FILE: design/buddy_page_allocator_top.sv
// Top level of the buddy page allocator: controller plus datapath.
// Every request passes decode and ends in the result state: init clears its pages and
// pushes one block per carve, allocate searches the order lists and then splits, and
// free checks each page's mark and then merges with free buddies.
// Throughput: one item at a time; a new beat can be taken once the result is valid.
// Reset: synchronous active low, then a pass over all 4096 pages clears the page marks.
module buddy_page_allocator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [11:0] i_page_index,
    input  logic [12:0] i_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [11:0] o_block_index,
    output logic [12:0] o_avail_pages,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [12:0] i_cfg_data
);
    import bpa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bpa_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_func        (i_func),
        .i_page_index  (i_page_index),
        .i_count       (i_count),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_block_index (o_block_index),
        .o_avail_pages (o_avail_pages)
    );

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the buddy page allocator: queued driver, result monitor, predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bpa_pkg::*;

    localparam int NP        = NUM_PAGES;
    localparam int CYC_LIMIT = 20000000;
    localparam logic [1:0] FN_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [11:0] page;
        logic [12:0] count;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] blk;
        logic [12:0] avail;
    } res_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_func = '0;
    logic [11:0] i_page_index = '0;
    logic [12:0] i_count = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_status;
    logic [11:0] o_block_index;
    logic [12:0] o_avail_pages;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [12:0] i_cfg_data = '0;

    buddy_page_allocator_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_func(i_func), .i_page_index(i_page_index), .i_count(i_count),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_status(o_status), .o_block_index(o_block_index), .o_avail_pages(o_avail_pages),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    // Allocator mirror
    bit   pg_mark[NP];
    int   pg_order[NP];
    int   pg_next[NP];
    int   pg_prev[NP];
    int   order_head[TOP_ORDER+1];
    int   free_cnt;
    int   present;

    // Page ranges held outside the free lists; only allocated ones may be freed
    int   hold_base[$];
    int   hold_size[$];
    bit   hold_alloc[$];

    req_t req_q[$];
    res_t result_q[$];
    int   err_count;
    int   cyc;
    bit   took;

    function automatic bit quiet();
        return cyc >= 60000 && cyc < 100000;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("tb_top: mismatch %s got %0d want %0d (cycle %0d)", what, got, want, cyc);
        err_count++;
    endtask

    function automatic int order_of(input int n);
        int o, sz;
        o = 0;
        sz = 1;
        while (sz < n) begin
            o++;
            sz <<= 1;
        end
        return o;
    endfunction

    function automatic void push_free(input int o, input int pg);
        int h;
        h = order_head[o];
        pg_next[pg] = h;
        pg_prev[pg] = NP;
        if (h < NP) pg_prev[h] = pg;
        order_head[o] = pg;
        pg_mark[pg] = 1'b1;
        pg_order[pg] = o;
    endfunction

    function automatic void unlink_free(input int o, input int pg);
        int nx, pv;
        nx = pg_next[pg];
        pv = pg_prev[pg];
        if (pv < NP) pg_next[pv] = nx;
        else order_head[o] = nx;
        if (nx < NP) pg_prev[nx] = pv;
    endfunction

    // Remove an initialized range from the held ranges, keeping the leftovers as holes
    function automatic void carve_holds(input int base, input int n);
        int nb[$], ns[$];
        bit na[$];
        int lo, hi;
        foreach (hold_base[k]) begin
            lo = hold_base[k];
            hi = lo + hold_size[k];
            if (hi <= base || lo >= base + n) begin
                nb.push_back(lo); ns.push_back(hold_size[k]); na.push_back(hold_alloc[k]);
            end else begin
                if (lo < base) begin
                    nb.push_back(lo); ns.push_back(base - lo); na.push_back(1'b0);
                end
                if (hi > base + n) begin
                    nb.push_back(base + n); ns.push_back(hi - base - n); na.push_back(1'b0);
                end
            end
        end
        hold_base = nb;
        hold_size = ns;
        hold_alloc = na;
    endfunction

    // Advance the mirror by one request and return the result it gives
    function automatic res_t apply_request(input req_t r);
        res_t e;
        int base, n, st, blk, o, rq, cur, b, sz, rem;
        bit ok;
        base = r.page;
        n = r.count;
        st = ST_BAD;
        blk = 0;
        if (n != 0 && r.func == FN_INIT) begin
            if (base + n <= NP && free_cnt + n <= NP) begin
                for (int i = base; i < base + n; i++) pg_mark[i] = 1'b0;
                free_cnt += n;
                cur = base;
                rem = n;
                while (rem > 0) begin
                    sz = 1;
                    o = 0;
                    while (o < TOP_ORDER && sz * 2 <= rem) begin
                        o++;
                        sz <<= 1;
                    end
                    push_free(o, cur);
                    cur += sz;
                    rem -= sz;
                end
                st = ST_OK;
                carve_holds(base, n);
            end
        end else if (n != 0 && r.func == FN_ALLOC) begin
            rq = order_of(n);
            st = ST_NOBLK;
            if (n <= free_cnt && rq <= TOP_ORDER) begin
                for (o = rq; o <= TOP_ORDER; o++)
                    if (order_head[o] < NP) break;
                if (o <= TOP_ORDER) begin
                    cur = order_head[o];
                    unlink_free(o, cur);
                    while (o > rq) begin
                        o--;
                        b = cur ^ (1 << o);
                        if (b < NP && b < present) push_free(o, b);
                    end
                    pg_mark[cur] = 1'b0;
                    free_cnt = free_cnt > (1 << rq) ? free_cnt - (1 << rq) : 0;
                    st = ST_OK;
                    blk = cur;
                    hold_base.push_back(cur);
                    hold_size.push_back(1 << rq);
                    hold_alloc.push_back(1'b1);
                end
            end
        end else if (n != 0 && r.func == FN_FREE) begin
            o = order_of(n);
            ok = o <= TOP_ORDER && base + n <= NP;
            if (ok && free_cnt + (1 << o) > NP) ok = 1'b0;
            if (ok)
                for (int i = base; i < base + n; i++)
                    if (pg_mark[i]) begin
                        ok = 1'b0;
                        break;
                    end
            if (ok) begin
                free_cnt += 1 << o;
                cur = base;
                while (o < TOP_ORDER) begin
                    b = cur ^ (1 << o);
                    if (!(b < present) || !pg_mark[b] || pg_order[b] != o) break;
                    unlink_free(o, b);
                    if (b < cur) begin
                        pg_mark[cur] = 1'b0;
                        cur = b;
                    end else begin
                        pg_mark[b] = 1'b0;
                    end
                    o++;
                end
                push_free(o, cur);
                st = ST_OK;
                foreach (hold_base[k])
                    if (hold_alloc[k] && hold_base[k] == base) begin
                        hold_base.delete(k);
                        hold_size.delete(k);
                        hold_alloc.delete(k);
                        break;
                    end
            end
        end
        e.status = st[1:0];
        e.blk = blk[11:0];
        e.avail = free_cnt[12:0];
        return e;
    endfunction

    // Clock and cycle limit
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("tb_top: timeout at cycle %0d", cyc);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Accept request beats and predict their results
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            result_q.push_back(apply_request(req_q[0]));
            void'(req_q.pop_front());
            took = 1'b1;
        end
    end

    // Drive request beats and the result stall
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_stall <= 1'b0;
        end else begin
            if (i_valid && !took) begin
                // hold the stalled beat
            end else if (req_q.size() > 0 && (quiet() || $urandom_range(99) >= 20)) begin
                i_valid      <= 1'b1;
                i_func       <= req_q[0].func;
                i_page_index <= req_q[0].page;
                i_count      <= req_q[0].count;
            end else begin
                i_valid <= 1'b0;
            end
            i_stall <= !quiet() && $urandom_range(99) < 20;
        end
        took = 1'b0;
    end

    // Check result beats against the oldest prediction
    always @(posedge i_clk) begin
        res_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (result_q.size() == 0) begin
                report_mismatch("unexpected result, status", o_status, -1);
            end else begin
                e = result_q.pop_front();
                if (o_status !== e.status) report_mismatch("status", o_status, e.status);
                if (o_block_index !== e.blk) report_mismatch("block_index", o_block_index, e.blk);
                if (o_avail_pages !== e.avail)
                    report_mismatch("avail_pages", o_avail_pages, e.avail);
            end
        end
    end

    task automatic issue(input logic [1:0] f, input int pg, input int n);
        req_t r;
        r.func = f;
        r.page = pg[11:0];
        r.count = n[12:0];
        req_q.push_back(r);
        while (req_q.size() > 0) @(negedge i_clk);
    endtask

    task automatic drain();
        while (req_q.size() > 0 || result_q.size() > 0) @(negedge i_clk);
    endtask

    task automatic write_present(input int v);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v[12:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        present = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random request, mostly well-formed against the current mirror
    task automatic random_request();
        int sel, k, off, n, cnt, lim;
        int picks[$];
        sel = $urandom_range(99);
        if (sel < 15 && hold_base.size() > 0) begin
            k = $urandom_range(hold_base.size() - 1);
            off = $urandom_range(hold_size[k] - 1);
            lim = hold_size[k] - off;
            if ($urandom_range(9) != 0 && lim > 64) lim = 64;
            issue(FN_INIT, hold_base[k] + off, $urandom_range(lim, 1));
        end else if (sel < 50) begin
            picks.delete();
            foreach (hold_alloc[j]) if (hold_alloc[j]) picks.push_back(j);
            if (picks.size() == 0) begin
                issue(FN_ALLOC, $urandom_range(4095), $urandom_range(16, 1));
            end else begin
                k = picks[$urandom_range(picks.size() - 1)];
                cnt = hold_size[k] > 1 ? $urandom_range(hold_size[k], hold_size[k] / 2 + 1) : 1;
                issue(FN_FREE, hold_base[k], cnt);
            end
        end else if (sel < 90) begin
            n = $urandom_range(19) == 0 ? $urandom_range(4096, 1) : $urandom_range(16, 1);
            issue(FN_ALLOC, $urandom_range(4095), n);
        end else begin
            case ($urandom_range(5))
                0: issue(FN_UNUSED, $urandom_range(4095), $urandom_range(8191));
                1: issue(2'($urandom_range(2)), $urandom_range(4095), 0);
                2: issue(FN_FREE, $urandom_range(4095), $urandom_range(8191, 4097));
                3: issue(FN_INIT, $urandom_range(4095, 3000), $urandom_range(8191, 4096));
                4: issue(FN_ALLOC, 0, $urandom_range(8191, 4097));
                default: begin
                    for (int o = 0; o <= TOP_ORDER; o++)
                        if (order_head[o] < NP) picks.push_back(order_head[o]);
                    if (picks.size() > 0)
                        issue(FN_FREE, picks[$urandom_range(picks.size() - 1)], 1);
                end
            endcase
        end
    endtask

    // Stimulus sequence and end of run
    initial begin
        int settings[6];
        err_count = 0;
        cyc = 0;
        took = 1'b0;
        present = NP;
        free_cnt = 0;
        for (int i = 0; i < NP; i++) begin
            pg_mark[i] = 1'b0;
            pg_order[i] = 0;
            pg_next[i] = 0;
            pg_prev[i] = 0;
        end
        for (int o = 0; o <= TOP_ORDER; o++) order_head[o] = NP;
        hold_base.push_back(0);
        hold_size.push_back(NP);
        hold_alloc.push_back(1'b0);

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_present(NP);

        // Directed requests: empty pool, bad codes, ranges and orders, full pool
        issue(FN_ALLOC, 0, 1);
        issue(FN_UNUSED, 4095, 8191);
        issue(FN_INIT, 0, 0);
        issue(FN_ALLOC, 0, 0);
        issue(FN_FREE, 0, 0);
        issue(FN_INIT, 4095, 2);
        issue(FN_INIT, 0, 4096);
        issue(FN_ALLOC, 4095, 4096);
        issue(FN_ALLOC, 0, 1);
        issue(FN_FREE, 0, 4096);
        issue(FN_FREE, 0, 4096);
        issue(FN_ALLOC, 0, 1);
        issue(FN_FREE, 2048, 1);
        issue(FN_FREE, 0, 8191);
        issue(FN_ALLOC, 0, 8191);
        issue(FN_FREE, 4095, 2);
        issue(FN_ALLOC, 0, 3);
        issue(FN_FREE, 0, 1);
        issue(FN_FREE, 4, 3);
        issue(FN_ALLOC, 0, 5000);

        settings[0] = 1;
        settings[1] = NP;
        settings[2] = $urandom_range(4095, 1);
        settings[3] = 2;
        settings[4] = $urandom_range(4095, 1);
        settings[5] = NP;
        foreach (settings[p]) begin
            drain();
            repeat (50) @(negedge i_clk);
            write_present(settings[p]);
            repeat (115) random_request();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
